>>> rtl/fptd_pkg.sv
// ----------------------------------------------------------------------------
// fptd_pkg
// Shared types and constants for the fft peak tone detector.
// ----------------------------------------------------------------------------
`default_nettype none

package fptd_pkg;

  localparam int unsigned MaxPointsDef = 1024;
  localparam int unsigned DataWidth    = 32;
  localparam int unsigned TwWidth      = 16;
  localparam int unsigned TwFrac       = TwWidth - 1;
  localparam int unsigned RateWidth    = 19;
  localparam int unsigned PeakWidth    = 10;
  localparam int unsigned SizeLogWidth = 4;
  localparam logic [RateWidth-1:0] RateReset = RateWidth'(44100);

  typedef enum logic [2:0] {
    W_SAMPLE = 3'd0,
    W_ZERO   = 3'd1,
    W_RDA    = 3'd2,
    W_RDB    = 3'd3,
    W_SUM    = 3'd4,
    W_DIFF   = 3'd5
  } wsel_e;

  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    wsel_e wsel;
    logic  prod_en;
    logic  sq_en;
    logic  cmp_en;
    logic  cmp_first;
    logic  out_load;
    logic  out_empty;
    logic  out_drop;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/fft_peak_tone_detector.sv
// ----------------------------------------------------------------------------
// fft_peak_tone_detector
// Radix-2 fft of one frame of samples, reports the strongest bin and its tone.
// ----------------------------------------------------------------------------
// Usage: samples enter on the input channel (in_valid_i / in_stall_o), one
// item per cycle while loading; the item with last_i set closes the frame.
// Samples beyond MaxPoints are dropped and flagged in overflow_o. The frame
// is zero padded to n = 2^fft_size_log points (at least 2).
// After the last item the input stalls while one shared butterfly unit runs;
// each butterfly is a read, a multiply and two writes on one memory write
// port.
// One result item per frame leaves on the output channel (out_valid_o /
// out_stall_i); it sits in an output register, so loading of the next frame
// starts as soon as the result is registered. A new result waits only while
// the previous one is still stalled.
// sample_rate is written at APB offset 0 and resets to 44100.
// Reset clears the sequencer and drops any frame in progress; memories need
// no clearing since every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module fft_peak_tone_detector #(
  parameter int unsigned MaxPoints = fptd_pkg::MaxPointsDef
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  signed [15:0]                   sample_i,
  input  wire                                  last_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [fptd_pkg::PeakWidth-1:0]       peak_bin_o,
  output logic [fptd_pkg::RateWidth-1:0]       tone_hz_o,
  output logic [fptd_pkg::SizeLogWidth-1:0]    fft_size_log_o,
  output logic                                 overflow_o,
  output logic                                 empty_res_o,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [2:0]                           paddr,
  input  wire  [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int unsigned Aw  = (MaxPoints > 2) ? $clog2(MaxPoints) : 1;
  localparam int unsigned Tww = (Aw > 1) ? Aw - 1 : 1;
  localparam int unsigned Lgw = $clog2(Aw + 1);

  logic [fptd_pkg::RateWidth-1:0] rate_q;
  fptd_pkg::cmd_t cmd;
  fptd_pkg::sts_t sts;
  logic [Aw-1:0]  rd_a, rd_b, wr_addr, bin_idx;
  logic [Tww-1:0] tw_idx;
  logic [Lgw-1:0] lg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= fptd_pkg::RateReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      rate_q <= pwdata[fptd_pkg::RateWidth-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : 32'(rate_q);
  assign pready = 1'b1;

  fptd_ctrl #(
    .MaxPoints (MaxPoints),
    .Aw        (Aw),
    .Tww       (Tww),
    .Lgw       (Lgw)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_a_o     (rd_a),
    .rd_b_o     (rd_b),
    .wr_addr_o  (wr_addr),
    .tw_idx_o   (tw_idx),
    .bin_idx_o  (bin_idx),
    .lg_o       (lg)
  );

  fptd_dp #(
    .MaxPoints (MaxPoints),
    .Aw        (Aw),
    .Tww       (Tww),
    .Lgw       (Lgw)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sample_i       (sample_i),
    .rd_a_i         (rd_a),
    .rd_b_i         (rd_b),
    .wr_addr_i      (wr_addr),
    .tw_idx_i       (tw_idx),
    .bin_idx_i      (bin_idx),
    .lg_i           (lg),
    .rate_i         (rate_q),
    .out_stall_i    (out_stall_i),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .peak_bin_o     (peak_bin_o),
    .tone_hz_o      (tone_hz_o),
    .fft_size_log_o (fft_size_log_o),
    .overflow_o     (overflow_o),
    .empty_res_o    (empty_res_o)
  );

endmodule

`default_nettype wire

>>> rtl/fptd_dp.sv
// ----------------------------------------------------------------------------
// fptd_dp
// Sample memories, twiddle rom, butterfly unit, magnitude search and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fptd_dp #(
  parameter int unsigned MaxPoints = fptd_pkg::MaxPointsDef,
  parameter int unsigned Aw        = (MaxPoints > 2) ? $clog2(MaxPoints) : 1,
  parameter int unsigned Tww       = (Aw > 1) ? Aw - 1 : 1,
  parameter int unsigned Lgw       = $clog2(Aw + 1)
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  fptd_pkg::cmd_t                       cmd_i,
  input  wire  signed [15:0]                   sample_i,
  input  wire  [Aw-1:0]                        rd_a_i,
  input  wire  [Aw-1:0]                        rd_b_i,
  input  wire  [Aw-1:0]                        wr_addr_i,
  input  wire  [Tww-1:0]                       tw_idx_i,
  input  wire  [Aw-1:0]                        bin_idx_i,
  input  wire  [Lgw-1:0]                       lg_i,
  input  wire  [fptd_pkg::RateWidth-1:0]       rate_i,
  input  wire                                  out_stall_i,
  output fptd_pkg::sts_t                       sts_o,
  output logic                                 out_valid_o,
  output logic [fptd_pkg::PeakWidth-1:0]       peak_bin_o,
  output logic [fptd_pkg::RateWidth-1:0]       tone_hz_o,
  output logic [fptd_pkg::SizeLogWidth-1:0]    fft_size_log_o,
  output logic                                 overflow_o,
  output logic                                 empty_res_o
);

  localparam int unsigned Dw      = fptd_pkg::DataWidth;
  localparam int unsigned Tw      = fptd_pkg::TwWidth;
  localparam int unsigned Rw      = fptd_pkg::RateWidth;
  localparam int unsigned Depth   = 1 << Aw;
  localparam int unsigned TwDepth = 1 << Tww;
  localparam int unsigned TwShift = Aw - 1;
  localparam longint unsigned TwHalf = 64'd1 << TwShift;
  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint unsigned OneQ30 = 64'd1 << 30;

  // elaboration-time long division for the rom contents
  function automatic longint unsigned div_u64(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [Tw-1:0] round_tw(input longint v);
    longint unsigned u;
    longint unsigned r;
    longint unsigned top;
    u   = (v < 0) ? 64'd0 : longint'(v);
    r   = (u + (64'd1 << (29 - fptd_pkg::TwFrac))) >> (30 - fptd_pkg::TwFrac);
    top = (64'd1 << fptd_pkg::TwFrac) - 64'd1;
    if (r > top) r = top;
    return r[Tw-1:0];
  endfunction

  function automatic logic [2*Tw-1:0] tw_entry(input longint unsigned k);
    longint unsigned jj;
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned tc;
    longint unsigned ts;
    longint unsigned n;
    longint          c_acc;
    longint          s_acc;
    logic            mirror;
    logic [Tw-1:0]   c;
    logic [Tw-1:0]   s;
    if (k >= TwHalf) return '0;
    mirror = (k * 2) > TwHalf;
    jj     = mirror ? TwHalf - k : k;
    theta  = (PiQ30 * jj) >> TwShift;
    t2     = (theta * theta) >> 30;
    tc     = OneQ30;
    ts     = theta;
    c_acc  = longint'(OneQ30);
    s_acc  = longint'(theta);
    for (n = 1; n <= 10; n++) begin
      tc = div_u64((tc * t2) >> 30, (2 * n - 1) * (2 * n));
      ts = div_u64((ts * t2) >> 30, (2 * n) * (2 * n + 1));
      if (n[0]) begin
        c_acc = c_acc - longint'(tc);
        s_acc = s_acc - longint'(ts);
      end else begin
        c_acc = c_acc + longint'(tc);
        s_acc = s_acc + longint'(ts);
      end
    end
    c = round_tw(c_acc);
    s = round_tw(s_acc);
    if (mirror) c = -c;
    return {c, s};
  endfunction

  logic [2*Tw-1:0] tw_rom [TwDepth];
  for (genvar g = 0; g < TwDepth; g++) begin : g_rom
    assign tw_rom[g] = tw_entry(g);
  end

  logic [Dw-1:0] re_mem [Depth];
  logic [Dw-1:0] im_mem [Depth];

  logic [Dw-1:0] rda_re_q, rda_im_q, rdb_re_q, rdb_im_q;
  logic [2*Tw-1:0] tw_q;
  logic signed [Dw+Tw-1:0] p_rc_q, p_is_q, p_ic_q, p_rs_q;
  logic [2*Dw-1:0] sq_re_q, sq_im_q, best_mag_q;
  logic [Aw-1:0] best_idx_q;
  logic out_valid_q;

  logic [Dw-1:0] wr_re, wr_im, t_re, t_im;
  logic signed [Dw+Tw-1:0] sh_rc, sh_is, sh_ic, sh_rs;
  logic [2*Dw-1:0] mag;
  logic [Aw+Rw-1:0] tone_prod, tone_sh;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      re_mem[wr_addr_i] <= wr_re;
      im_mem[wr_addr_i] <= wr_im;
    end
    if (cmd_i.rd_en) begin
      rda_re_q <= re_mem[rd_a_i];
      rda_im_q <= im_mem[rd_a_i];
      rdb_re_q <= re_mem[rd_b_i];
      rdb_im_q <= im_mem[rd_b_i];
      tw_q     <= tw_rom[tw_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      p_rc_q <= $signed(rdb_re_q) * $signed(tw_q[2*Tw-1:Tw]);
      p_is_q <= $signed(rdb_im_q) * $signed(tw_q[Tw-1:0]);
      p_ic_q <= $signed(rdb_im_q) * $signed(tw_q[2*Tw-1:Tw]);
      p_rs_q <= $signed(rdb_re_q) * $signed(tw_q[Tw-1:0]);
    end
    if (cmd_i.sq_en) begin
      sq_re_q <= $signed(rda_re_q) * $signed(rda_re_q);
      sq_im_q <= $signed(rda_im_q) * $signed(rda_im_q);
    end
  end

  always_comb begin
    sh_rc = p_rc_q >>> fptd_pkg::TwFrac;
    sh_is = p_is_q >>> fptd_pkg::TwFrac;
    sh_ic = p_ic_q >>> fptd_pkg::TwFrac;
    sh_rs = p_rs_q >>> fptd_pkg::TwFrac;
    t_re  = sh_rc[Dw-1:0] + sh_is[Dw-1:0];
    t_im  = sh_ic[Dw-1:0] - sh_rs[Dw-1:0];
    mag   = sq_re_q + sq_im_q;
  end

  always_comb begin
    case (cmd_i.wsel)
      fptd_pkg::W_SAMPLE: begin
        wr_re = Dw'(sample_i);
        wr_im = '0;
      end
      fptd_pkg::W_RDA: begin
        wr_re = rda_re_q;
        wr_im = rda_im_q;
      end
      fptd_pkg::W_RDB: begin
        wr_re = rdb_re_q;
        wr_im = rdb_im_q;
      end
      fptd_pkg::W_SUM: begin
        wr_re = rda_re_q + t_re;
        wr_im = rda_im_q + t_im;
      end
      fptd_pkg::W_DIFF: begin
        wr_re = rda_re_q - t_re;
        wr_im = rda_im_q - t_im;
      end
      default: begin
        wr_re = '0;
        wr_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en && (cmd_i.cmp_first || mag > best_mag_q)) begin
      best_mag_q <= mag;
      best_idx_q <= bin_idx_i;
    end
  end

  // tone = bin * rate / n, n a power of two
  always_comb begin
    tone_prod = (Aw+Rw)'(best_idx_q) * (Aw+Rw)'(rate_i);
    tone_sh   = tone_prod >> lg_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      peak_bin_o     <= cmd_i.out_empty ? '0 : fptd_pkg::PeakWidth'(best_idx_q);
      tone_hz_o      <= cmd_i.out_empty ? '0 : tone_sh[Rw-1:0];
      fft_size_log_o <= fptd_pkg::SizeLogWidth'(lg_i);
      overflow_o     <= cmd_i.out_drop;
      empty_res_o    <= cmd_i.out_empty;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

>>> rtl/fptd_ctrl.sv
// ----------------------------------------------------------------------------
// fptd_ctrl
// Frame sequencer: load, zero pad, bit reversal, butterfly stages, peak
// search and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module fptd_ctrl #(
  parameter int unsigned MaxPoints = fptd_pkg::MaxPointsDef,
  parameter int unsigned Aw        = (MaxPoints > 2) ? $clog2(MaxPoints) : 1,
  parameter int unsigned Tww       = (Aw > 1) ? Aw - 1 : 1,
  parameter int unsigned Lgw       = $clog2(Aw + 1)
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  last_i,
  output logic                 in_stall_o,
  input  fptd_pkg::sts_t       sts_i,
  output fptd_pkg::cmd_t       cmd_o,
  output logic [Aw-1:0]        rd_a_o,
  output logic [Aw-1:0]        rd_b_o,
  output logic [Aw-1:0]        wr_addr_o,
  output logic [Tww-1:0]       tw_idx_o,
  output logic [Aw-1:0]        bin_idx_o,
  output logic [Lgw-1:0]       lg_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_PAD    = 12'b000000000010,
    S_REV    = 12'b000000000100,
    S_SWP1   = 12'b000000001000,
    S_SWP2   = 12'b000000010000,
    S_BF_RD  = 12'b000000100000,
    S_BF_MUL = 12'b000001000000,
    S_BF_WK  = 12'b000010000000,
    S_BF_WI  = 12'b000100000000,
    S_MAG_RD = 12'b001000000000,
    S_MAG_SQ = 12'b010000000000,
    S_MAG_CM = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [Aw:0]    cnt_q, cnt_d, ptr_q, ptr_d, n_pts, cnt_inc;
  logic           drop_q, drop_d, done_q, done_d;
  logic [Lgw-1:0] lg_q, lg_d, stg_q, stg_d;
  logic [Tww-1:0] bf_q, bf_d, hmask, jdx, grp, bf_last;
  logic [Aw-1:0]  bi, bk, rev_full, rev, ptr_a;

  always_comb begin
    n_pts   = (Aw+1)'(1) << lg_q;
    cnt_inc = cnt_q + (Aw+1)'(1);
    ptr_a   = ptr_q[Aw-1:0];
    for (int b = 0; b < Aw; b++) rev_full[b] = ptr_a[Aw-1-b];
    rev     = rev_full >> (Lgw'(Aw) - lg_q);
    hmask   = (Tww'(1) << (stg_q - Lgw'(1))) - Tww'(1);
    jdx     = bf_q & hmask;
    grp     = bf_q >> (stg_q - Lgw'(1));
    bi      = (Aw'(grp) << stg_q) | Aw'(jdx);
    bk      = bi | (Aw'(1) << (stg_q - Lgw'(1)));
    bf_last = (Tww'(1) << (lg_q - Lgw'(1))) - Tww'(1);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    lg_d    = lg_q;
    ptr_d   = ptr_q;
    stg_d   = stg_q;
    bf_d    = bf_q;
    done_d  = done_q;
    cmd_o   = '0;
    cmd_o.wsel      = fptd_pkg::W_ZERO;
    cmd_o.out_empty = (cnt_q == '0);
    cmd_o.out_drop  = drop_q;
    rd_a_o    = ptr_a;
    rd_b_o    = rev;
    wr_addr_o = ptr_a;
    tw_idx_o  = Tww'(jdx << (Lgw'(Aw) - stg_q));
    bin_idx_o = ptr_a;
    in_stall_o = (state_q != S_IDLE) || done_q;
    case (state_q)
      S_IDLE: begin
        if (done_q) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cnt_d  = '0;
            drop_d = 1'b0;
            lg_d   = Lgw'(1);
            done_d = 1'b0;
          end
        end else if (in_valid_i) begin
          wr_addr_o = cnt_q[Aw-1:0];
          if (cnt_q < (Aw+1)'(MaxPoints)) begin
            cmd_o.wr_en = 1'b1;
            cmd_o.wsel  = fptd_pkg::W_SAMPLE;
            cnt_d = cnt_inc;
            if (cnt_inc > n_pts) lg_d = lg_q + Lgw'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_i) begin
            state_d = S_PAD;
            ptr_d   = cnt_d;
          end
        end
      end
      S_PAD: begin
        if (ptr_q >= n_pts) begin
          state_d = S_REV;
          ptr_d   = '0;
        end else begin
          cmd_o.wr_en = 1'b1;
          ptr_d = ptr_q + (Aw+1)'(1);
        end
      end
      S_REV, S_SWP2: begin
        if (state_q == S_SWP2) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wsel  = fptd_pkg::W_RDB;
        end
        if (state_q == S_REV && ptr_a < rev) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_SWP1;
        end else if (ptr_q == n_pts - (Aw+1)'(1)) begin
          state_d = S_BF_RD;
          stg_d   = Lgw'(1);
          bf_d    = '0;
        end else begin
          state_d = S_REV;
          ptr_d   = ptr_q + (Aw+1)'(1);
        end
      end
      S_SWP1: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = fptd_pkg::W_RDA;
        wr_addr_o   = rev;
        state_d     = S_SWP2;
      end
      S_BF_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_a_o  = bi;
        rd_b_o  = bk;
        state_d = S_BF_MUL;
      end
      S_BF_MUL: begin
        cmd_o.prod_en = 1'b1;
        state_d = S_BF_WK;
      end
      S_BF_WK: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = fptd_pkg::W_DIFF;
        wr_addr_o   = bk;
        state_d     = S_BF_WI;
      end
      S_BF_WI: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = fptd_pkg::W_SUM;
        wr_addr_o   = bi;
        state_d     = S_BF_RD;
        if (bf_q == bf_last) begin
          bf_d = '0;
          if (stg_q == lg_q) begin
            state_d = S_MAG_RD;
            ptr_d   = '0;
          end else begin
            stg_d = stg_q + Lgw'(1);
          end
        end else begin
          bf_d = bf_q + Tww'(1);
        end
      end
      S_MAG_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_MAG_SQ;
      end
      S_MAG_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d = S_MAG_CM;
      end
      S_MAG_CM: begin
        cmd_o.cmp_en    = 1'b1;
        cmd_o.cmp_first = (ptr_q == '0);
        if (ptr_q == cnt_q - (Aw+1)'(1)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = S_MAG_RD;
          ptr_d   = ptr_q + (Aw+1)'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      done_q  <= 1'b0;
      lg_q    <= Lgw'(1);
      ptr_q   <= '0;
      stg_q   <= Lgw'(1);
      bf_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      done_q  <= done_d;
      lg_q    <= lg_d;
      ptr_q   <= ptr_d;
      stg_q   <= stg_d;
      bf_q    <= bf_d;
    end
  end

  assign lg_o = lg_q;

endmodule

`default_nettype wire
